/* sv/crts_pkg.sv */
// Shared types, codes and constants of the channel reset timeout scanner.
`default_nettype none

package crts_pkg;

    // Default values of the top-level parameters
    localparam int DEF_MAX_CHANNELS     = 8;
    localparam int DEF_IDLE_COUNT_LIMIT = 4;
    localparam int DEF_SEQ_BITS         = 4;
    localparam int DEF_TIMER_BITS       = 20;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int CHAN_W    = 3;
    localparam int ELAPSED_W = 16;
    localparam int RSEQ_W    = 4;
    localparam int KIND_W    = 3;
    localparam int PSEQ_W    = 4;
    localparam int TCNT_W    = 4;
    localparam int SCAN_W    = 4;
    localparam int TIMO_W    = 16;
    localparam int LIMIT_W   = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_RXRST  = 3'd2;
    localparam logic [OP_W-1:0] OP_RXDONE = 3'd3;
    localparam logic [OP_W-1:0] OP_TXDONE = 3'd4;
    localparam logic [OP_W-1:0] OP_DATA   = 3'd5;
    localparam logic [OP_W-1:0] OP_IDLE   = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIMO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECV_TIMO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAN = 2'd3;

    // Configuration reset values
    localparam logic [TIMO_W-1:0] RST_SHORT_TIMO = 16'd10;
    localparam logic [TIMO_W-1:0] RST_RECV_TIMO  = 16'd5;
    localparam logic [SCAN_W-1:0] RST_CHAN_COUNT = 4'd8;
    localparam logic [CHAN_W-1:0] RST_FIRST_CHAN = 3'd0;

    // Control packet kinds
    typedef enum logic [KIND_W-1:0] {
        PK_REQ  = 3'd0,
        PK_XMT  = 3'd1,
        PK_TIMO = 3'd2,
        PK_IDLE = 3'd3,
        PK_END  = 3'd4
    } pkt_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      accept;
        logic      step_tx;
        logic      step_rx;
        logic      out_load;
        pkt_kind_t out_kind;
        logic      out_last;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic      go_scan;
        logic      go_req;
        logic      go_xmt;
        logic      go_idle;
        logic      xmt_after;
        logic      scan_more;
        logic      tx_fire;
        logic      rx_fire;
        pkt_kind_t rx_kind;
        logic      out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

/* sv/channel_reset_timeout_scanner.sv */
// Top level of the channel reset timeout scanner.
//
// One operation is taken at a time; item_stall stays high until its last
// result has been loaded into the output register. Operations that send no
// packet are done once accepted. Start channel, start receive reset and
// idle prompt load their packets one after another. A tick scan
// updates, for each visited channel, first the transmit and activity timers
// and then the receive timer, since each step reads the per-channel state
// at one index; the controller then sees the scan end and sends the end
// marker. Any cycle in which a packet meets a full, stalled output register
// is repeated. Configuration writes are always ready and must only be made
// while no operation is in progress.
`default_nettype none

module channel_reset_timeout_scanner
    import crts_pkg::*;
#(
    parameter int MAX_CHANNELS     = DEF_MAX_CHANNELS,
    parameter int IDLE_COUNT_LIMIT = DEF_IDLE_COUNT_LIMIT,
    parameter int SEQ_BITS         = DEF_SEQ_BITS,
    parameter int TIMER_BITS       = DEF_TIMER_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  logic [RSEQ_W-1:0]    receive_sequence,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [KIND_W-1:0]    packet_kind,
    output logic [CHAN_W-1:0]    packet_channel,
    output logic [PSEQ_W-1:0]    packet_sequence,
    output logic                 all_inactive,
    output logic                 last
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    crts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    crts_datapath #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .IDLE_COUNT_LIMIT (IDLE_COUNT_LIMIT),
        .SEQ_BITS         (SEQ_BITS),
        .TIMER_BITS       (TIMER_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .channel          (channel),
        .elapsed          (elapsed),
        .receive_sequence (receive_sequence),
        .result_stall     (result_stall),
        .cmd              (cmd),
        .sts              (sts),
        .result_valid     (result_valid),
        .packet_kind      (packet_kind),
        .packet_channel   (packet_channel),
        .packet_sequence  (packet_sequence),
        .all_inactive     (all_inactive),
        .last             (last)
    );

    // An end marker always closes its operation
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (packet_kind == PK_END) |-> last)
        else $error("end marker without last");

    // Only the end marker carries the inactive flag
    a_inact_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (packet_kind != PK_END) |-> !all_inactive)
        else $error("inactive flag on a packet");

    // No new operation while a result of the current one is still to follow
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> item_stall)
        else $error("operation accepted before last result");

    // A packet load never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(result_valid && result_stall))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* sv/crts_ctrl.sv */
// Sequencing state machine of the channel reset timeout scanner.
`default_nettype none

module crts_ctrl
    import crts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_TX       = 7'b0000010,
        ST_RX       = 7'b0000100,
        ST_REQ      = 7'b0001000,
        ST_XMT      = 7'b0010000,
        ST_IDLE_PKT = 7'b0100000,
        ST_END      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new transaction only between operations
    assign item_stall = (state_reg != ST_IDLE);

    // Decide the next step and the datapath command
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_kind = PK_END;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.go_scan)
                        state_next = ST_TX;
                    else if (sts.go_req)
                        state_next = ST_REQ;
                    else if (sts.go_xmt)
                        state_next = ST_XMT;
                    else if (sts.go_idle)
                        state_next = ST_IDLE_PKT;
                end
            end
            ST_TX:
            begin
                if (!sts.scan_more)
                    state_next = ST_END;
                else if (!(sts.tx_fire && !sts.out_free))
                begin
                    cmd.step_tx  = 1'b1;
                    cmd.out_load = sts.tx_fire;
                    cmd.out_kind = PK_REQ;
                    state_next   = ST_RX;
                end
            end
            ST_RX:
            begin
                if (!(sts.rx_fire && !sts.out_free))
                begin
                    cmd.step_rx  = 1'b1;
                    cmd.out_load = sts.rx_fire;
                    cmd.out_kind = sts.rx_kind;
                    state_next   = ST_TX;
                end
            end
            ST_REQ:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = PK_REQ;
                    cmd.out_last = !sts.xmt_after;
                    state_next   = sts.xmt_after ? ST_XMT : ST_IDLE;
                end
            end
            ST_XMT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = PK_XMT;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE_PKT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = PK_IDLE;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_END:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = PK_END;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* sv/crts_datapath.sv */
// Per-channel state, timer arithmetic, configuration and result register.
`default_nettype none

module crts_datapath
    import crts_pkg::*;
#(
    parameter int MAX_CHANNELS     = DEF_MAX_CHANNELS,
    parameter int IDLE_COUNT_LIMIT = DEF_IDLE_COUNT_LIMIT,
    parameter int SEQ_BITS         = DEF_SEQ_BITS,
    parameter int TIMER_BITS       = DEF_TIMER_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [OP_W-1:0]      operation,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  logic [RSEQ_W-1:0]    receive_sequence,
    input  logic                 result_stall,
    input  ctl_cmd_t             cmd,
    output ctl_sts_t             sts,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    packet_kind,
    output logic [CHAN_W-1:0]    packet_channel,
    output logic [PSEQ_W-1:0]    packet_sequence,
    output logic                 all_inactive,
    output logic                 last
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = TIMER_BITS + 2;
    localparam logic [TCNT_W-1:0] TC_LIMIT = TCNT_W'(IDLE_COUNT_LIMIT);
    localparam logic [TCNT_W-1:0] TC_MAX   = '1;
    localparam logic [TIMER_BITS-1:0] TMR_ONE = TIMER_BITS'(1);

    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] a,
        input logic [ELAPSED_W-1:0]  b
    );
        logic [TIMER_BITS:0] s;
        s = {1'b0, a} + (TIMER_BITS+1)'(b);
        return s[TIMER_BITS] ? '1 : s[TIMER_BITS-1:0];
    endfunction

    // Configuration
    logic [TIMO_W-1:0] short_reg;
    logic [TIMO_W-1:0] recv_reg;
    logic [SCAN_W-1:0] count_reg;
    logic [CHAN_W-1:0] first_reg;

    // Per-channel state
    logic [MAX_CHANNELS-1:0] tx_rst_reg;
    logic [MAX_CHANNELS-1:0] rx_rst_reg;
    logic [TIMER_BITS-1:0]   tx_tmr_reg  [MAX_CHANNELS];
    logic [TIMER_BITS-1:0]   rx_tmr_reg  [MAX_CHANNELS];
    logic [TIMER_BITS-1:0]   act_tmr_reg [MAX_CHANNELS];
    logic [TCNT_W-1:0]       tcnt_reg    [MAX_CHANNELS];
    logic [SEQ_BITS-1:0]     rseq_reg    [MAX_CHANNELS];

    // Working registers of the current operation
    logic [ELAPSED_W-1:0] el_reg;
    logic [SCAN_W-1:0]    cur_reg;
    logic [SCAN_W-1:0]    inact_reg;
    logic                 xmt_after_reg;
    logic [LIMIT_W-1:0]   rs_timo_reg;

    // Result register
    logic                 out_valid_reg;
    pkt_kind_t            out_kind_reg;
    logic [CHAN_W-1:0]    out_chan_reg;
    logic [PSEQ_W-1:0]    out_seq_reg;
    logic                 out_inact_reg;
    logic                 out_last_reg;

    logic [SCAN_W-1:0]    scan_end;
    logic [IDX_W-1:0]     cur_idx;
    logic [IDX_W-1:0]     item_idx;
    logic [IDX_W-1:0]     first_idx;
    logic                 item_ok;
    logic                 first_ok;
    logic [LIMIT_W-1:0]   ia_timo;

    logic [TIMER_BITS-1:0] tx_sum;
    logic [TIMER_BITS-1:0] tx_next;
    logic                  act_over;
    logic [TIMER_BITS-1:0] act_next;
    logic [TIMER_BITS-1:0] rx_sum;
    logic [TIMER_BITS-1:0] rx_next;
    logic [LIMIT_W-1:0]    rx_limit;
    logic [TIMO_W-1:0]     idle_limit;
    logic [TCNT_W-1:0]     tc_base;
    logic [TCNT_W-1:0]     tc_next;
    logic                  tx_fire;
    logic                  rx_fire;
    logic [SEQ_BITS-1:0]   seq_prev;
    logic                  out_free;

    // Clamp the scan end and form indexes
    assign scan_end  = (int'(count_reg) > MAX_CHANNELS) ? SCAN_W'(MAX_CHANNELS) : count_reg;
    assign cur_idx   = IDX_W'(cur_reg);
    assign item_idx  = IDX_W'(channel);
    assign first_idx = IDX_W'(first_reg);
    assign item_ok   = int'(channel) < MAX_CHANNELS;
    assign first_ok  = int'(first_reg) < MAX_CHANNELS;
    assign ia_timo   = {short_reg, 2'b00};

    // Transmit reset timer and activity timer of the current channel
    always_comb
    begin
        tx_sum   = sat_add(tx_tmr_reg[cur_idx], el_reg);
        tx_fire  = tx_rst_reg[cur_idx] && (CMP_W'(tx_sum) > CMP_W'(rs_timo_reg));
        tx_next  = tx_fire ? TMR_ONE : tx_sum;
        act_over = CMP_W'(act_tmr_reg[cur_idx]) > CMP_W'(ia_timo);
        act_next = sat_add(act_tmr_reg[cur_idx], el_reg);
    end

    // Receive timer and timeout count of the current channel
    always_comb
    begin
        rx_sum     = sat_add(rx_tmr_reg[cur_idx], el_reg);
        rx_limit   = '0;
        idle_limit = recv_reg;
        tc_base    = tcnt_reg[cur_idx];
        tc_next    = tc_base;
        if (rx_rst_reg[cur_idx])
        begin
            rx_limit = tx_rst_reg[cur_idx] ? rs_timo_reg : LIMIT_W'(short_reg);
            rx_fire  = CMP_W'(rx_sum) > CMP_W'(rx_limit);
        end
        else
        begin
            if (rx_tmr_reg[cur_idx] == '0)
                tc_base = '0;
            else if (tcnt_reg[cur_idx] >= TC_LIMIT)
            begin
                tc_base    = TC_LIMIT;
                idle_limit = short_reg;
            end
            if (el_reg > idle_limit)
                idle_limit = el_reg;
            rx_fire = CMP_W'(rx_sum) > CMP_W'(idle_limit);
            if (rx_fire && tc_base != TC_MAX)
                tc_next = tc_base + TCNT_W'(1);
            else
                tc_next = tc_base;
        end
        rx_next  = rx_fire ? TMR_ONE : rx_sum;
        seq_prev = rseq_reg[cur_idx] - SEQ_BITS'(1);
    end

    assign out_free = !out_valid_reg || !result_stall;

    // Status toward the controller
    always_comb
    begin
        sts.go_scan   = (operation == OP_TICK);
        sts.go_req    = (operation == OP_START) && item_ok;
        sts.go_xmt    = (operation == OP_RXRST) && item_ok && (channel >= first_reg);
        sts.go_idle   = (operation == OP_IDLE) && first_ok && !tx_rst_reg[first_idx];
        sts.xmt_after = xmt_after_reg;
        sts.scan_more = cur_reg < scan_end;
        sts.tx_fire   = tx_fire;
        sts.rx_fire   = rx_fire;
        sts.rx_kind   = rx_rst_reg[cur_idx] ? PK_XMT : PK_TIMO;
        sts.out_free  = out_free;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= RST_SHORT_TIMO;
            recv_reg  <= RST_RECV_TIMO;
            count_reg <= RST_CHAN_COUNT;
            first_reg <= RST_FIRST_CHAN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SHORT_TIMO: short_reg <= cfg_data;
                REG_RECV_TIMO:  recv_reg  <= cfg_data;
                REG_CHAN_COUNT: count_reg <= cfg_data[SCAN_W-1:0];
                REG_FIRST_CHAN: first_reg <= cfg_data[CHAN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Latch the operation and advance the scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            el_reg        <= '0;
            cur_reg       <= '0;
            inact_reg     <= '0;
            xmt_after_reg <= 1'b0;
            rs_timo_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            el_reg        <= elapsed;
            inact_reg     <= SCAN_W'(first_reg);
            xmt_after_reg <= channel >= first_reg;
            rs_timo_reg   <= {2'b00, short_reg} + {1'b0, short_reg, 1'b0};
            if (operation == OP_TICK || operation == OP_IDLE)
                cur_reg <= SCAN_W'(first_reg);
            else
                cur_reg <= SCAN_W'(channel);
        end
        else
        begin
            if (cmd.step_tx && act_over)
                inact_reg <= inact_reg + SCAN_W'(1);
            if (cmd.step_rx)
                cur_reg <= cur_reg + SCAN_W'(1);
        end
    end

    // Update per-channel state for single operations and scan steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_rst_reg <= '0;
            rx_rst_reg <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                tx_tmr_reg[i]  <= '0;
                rx_tmr_reg[i]  <= '0;
                act_tmr_reg[i] <= '0;
                tcnt_reg[i]    <= '0;
                rseq_reg[i]    <= '0;
            end
        end
        else if (cmd.accept)
        begin
            if (item_ok)
            begin
                case (operation)
                    OP_START:
                    begin
                        tx_rst_reg[item_idx]  <= 1'b1;
                        tx_tmr_reg[item_idx]  <= TIMER_BITS'({short_reg, 1'b0});
                        act_tmr_reg[item_idx] <= '0;
                        rx_tmr_reg[item_idx]  <= TMR_ONE;
                        tcnt_reg[item_idx]    <= TC_LIMIT;
                        rx_rst_reg[item_idx]  <= 1'b1;
                    end
                    OP_RXRST:
                    begin
                        act_tmr_reg[item_idx] <= '0;
                        rx_tmr_reg[item_idx]  <= TMR_ONE;
                        tcnt_reg[item_idx]    <= TC_LIMIT;
                        rx_rst_reg[item_idx]  <= 1'b1;
                    end
                    OP_RXDONE:
                    begin
                        rseq_reg[item_idx]   <= '0;
                        rx_rst_reg[item_idx] <= 1'b0;
                    end
                    OP_TXDONE:
                    begin
                        tx_rst_reg[item_idx] <= 1'b0;
                    end
                    OP_DATA:
                    begin
                        rx_tmr_reg[item_idx]  <= '0;
                        act_tmr_reg[item_idx] <= '0;
                        rseq_reg[item_idx]    <= SEQ_BITS'(receive_sequence);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            if (cmd.step_tx)
            begin
                if (tx_rst_reg[cur_idx])
                    tx_tmr_reg[cur_idx] <= tx_next;
                if (!act_over)
                    act_tmr_reg[cur_idx] <= act_next;
            end
            if (cmd.step_rx)
            begin
                rx_tmr_reg[cur_idx] <= rx_next;
                tcnt_reg[cur_idx]   <= tc_next;
            end
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg  <= cmd.out_kind;
            out_last_reg  <= cmd.out_last;
            out_chan_reg  <= (cmd.out_kind == PK_END) ? '0 : cur_reg[CHAN_W-1:0];
            out_seq_reg   <= (cmd.out_kind == PK_TIMO) ? PSEQ_W'(seq_prev) : '0;
            out_inact_reg <= (cmd.out_kind == PK_END) && (inact_reg == scan_end);
        end
    end

    assign result_valid    = out_valid_reg;
    assign packet_kind     = out_kind_reg;
    assign packet_channel  = out_chan_reg;
    assign packet_sequence = out_seq_reg;
    assign all_inactive    = out_inact_reg;
    assign last            = out_last_reg;

endmodule

`default_nettype wire
